/* hdl/rgb_to_cie_xy_chromaticity_assert.svh */
// Assertion macros for the chromaticity block; clk_i and rst_ni must be in scope.
`ifndef RGB_TO_CIE_XY_CHROMATICITY_ASSERT_SVH
`define RGB_TO_CIE_XY_CHROMATICITY_ASSERT_SVH

// same-cycle implication
`define RCXY_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rcxy assertion failed");

// next-cycle implication
`define RCXY_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rcxy assertion failed");

`endif

/* hdl/rcxy_pkg.sv */
`timescale 1ns / 1ps

package rcxy_pkg;

  localparam int unsigned WsumW  = 19;
  localparam int unsigned TriW   = 9;
  localparam int unsigned SumW   = 10;
  localparam int unsigned RemW   = 11;
  localparam int unsigned QuotW  = 9;
  localparam int unsigned NCells = 9;

  localparam logic [WsumW-1:0] CoefXR = 19'd607;
  localparam logic [WsumW-1:0] CoefXG = 19'd174;
  localparam logic [WsumW-1:0] CoefXB = 19'd200;
  localparam logic [WsumW-1:0] CoefYR = 19'd299;
  localparam logic [WsumW-1:0] CoefYG = 19'd587;
  localparam logic [WsumW-1:0] CoefYB = 19'd114;
  localparam logic [WsumW-1:0] CoefZG = 19'd66;
  localparam logic [WsumW-1:0] CoefZB = 19'd1111;

  // floor(v / 1000) == (v * RecipK) >> RecipSh for v below 493447,
  // which covers the largest weighted sum of 300135
  localparam int unsigned RecipW  = 2 * WsumW;
  localparam int unsigned RecipSh = 28;
  localparam logic [RecipW-1:0] RecipK = 38'd268436;

  localparam logic [7:0] ChromaMax = 8'd255;

  typedef struct packed {
    logic [RemW-1:0]  t_x;
    logic [RemW-1:0]  t_y;
    logic [SumW-1:0]  s;
    logic [QuotW-1:0] q_x;
    logic [QuotW-1:0] q_y;
    logic             black;
  } cell_t;

  function automatic logic [TriW-1:0] div1000(input logic [WsumW-1:0] v);
    logic [RecipW-1:0] p;
    p = RecipW'(v) * RecipK;
    return p[RecipSh +: TriW];
  endfunction

endpackage

/* hdl/rcxy_tristim.sv */
`timescale 1ns / 1ps

module rcxy_tristim (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  logic [7:0]      red_i,
  input  logic [7:0]      green_i,
  input  logic [7:0]      blue_i,
  output logic            valid_o,
  input  logic            ready_i,
  output rcxy_pkg::cell_t word_o
);

  logic [2:0] v_q, v_d;
  logic [2:0] rdy;

  logic [rcxy_pkg::WsumW-1:0] wx_q, wy_q, wz_q;
  logic [rcxy_pkg::TriW-1:0]  tx_q, ty_q, tz_q;
  rcxy_pkg::cell_t            word_q;

  logic [rcxy_pkg::WsumW-1:0] r_w, g_w, b_w;
  logic [rcxy_pkg::SumW-1:0]  sum_w;

  assign r_w = rcxy_pkg::WsumW'(red_i);
  assign g_w = rcxy_pkg::WsumW'(green_i);
  assign b_w = rcxy_pkg::WsumW'(blue_i);

  assign sum_w = rcxy_pkg::SumW'(tx_q) + rcxy_pkg::SumW'(ty_q) + rcxy_pkg::SumW'(tz_q);

  assign rdy[2] = !v_q[2] || ready_i;
  assign rdy[1] = !v_q[1] || rdy[2];
  assign rdy[0] = !v_q[0] || rdy[1];

  always_comb begin
    v_d = v_q;
    if (rdy[0]) v_d[0] = valid_i;
    if (rdy[1]) v_d[1] = v_q[0];
    if (rdy[2]) v_d[2] = v_q[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && valid_i) begin
      wx_q <= rcxy_pkg::CoefXR * r_w + rcxy_pkg::CoefXG * g_w + rcxy_pkg::CoefXB * b_w;
      wy_q <= rcxy_pkg::CoefYR * r_w + rcxy_pkg::CoefYG * g_w + rcxy_pkg::CoefYB * b_w;
      wz_q <= rcxy_pkg::CoefZG * g_w + rcxy_pkg::CoefZB * b_w;
    end
    if (rdy[1] && v_q[0]) begin
      tx_q <= rcxy_pkg::div1000(wx_q);
      ty_q <= rcxy_pkg::div1000(wy_q);
      tz_q <= rcxy_pkg::div1000(wz_q);
    end
    if (rdy[2] && v_q[1]) begin
      word_q.t_x   <= rcxy_pkg::RemW'(tx_q);
      word_q.t_y   <= rcxy_pkg::RemW'(ty_q);
      word_q.s     <= sum_w;
      word_q.q_x   <= '0;
      word_q.q_y   <= '0;
      word_q.black <= (sum_w == '0);
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = v_q[2];
  assign word_o  = word_q;

endmodule

/* hdl/rcxy_div_cell.sv */
`timescale 1ns / 1ps

module rcxy_div_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  rcxy_pkg::cell_t word_i,
  output logic            valid_o,
  input  logic            ready_i,
  output rcxy_pkg::cell_t word_o
);

  logic            valid_q, valid_d;
  rcxy_pkg::cell_t word_q, word_d;

  logic [rcxy_pkg::RemW-1:0] s_w, rx_w, ry_w;
  logic                      bx_w, by_w;

  assign s_w  = rcxy_pkg::RemW'(word_i.s);
  assign bx_w = (word_i.t_x >= s_w);
  assign by_w = (word_i.t_y >= s_w);
  assign rx_w = bx_w ? (word_i.t_x - s_w) : word_i.t_x;
  assign ry_w = by_w ? (word_i.t_y - s_w) : word_i.t_y;

  always_comb begin
    word_d       = word_i;
    word_d.t_x   = {rx_w[rcxy_pkg::RemW-2:0], 1'b0};
    word_d.t_y   = {ry_w[rcxy_pkg::RemW-2:0], 1'b0};
    word_d.q_x   = {word_i.q_x[rcxy_pkg::QuotW-2:0], bx_w};
    word_d.q_y   = {word_i.q_y[rcxy_pkg::QuotW-2:0], by_w};
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

/* hdl/rgb_to_cie_xy_chromaticity.sv */
`timescale 1ns / 1ps

// Per pixel, converts 8-bit R, G, B to CIE xy chromaticity scaled by 256 and saturated
// at 255, with a black flag (and zero chroma) when X, Y and Z all truncate to zero.
// One pixel is taken every clock while no stall reaches the input. From input to output word,
// registers form the weighted sums, then X, Y, Z, then their sum; a row of nine divider cells
// produces one quotient bit each for x and y, and the result is saturated into the output register.
// Backpressure on the output stalls only the cells that hold data.
module rgb_to_cie_xy_chromaticity (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // red [7:0], green [15:8], blue [23:16]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // chroma_x [7:0], chroma_y [15:8]
  output logic        m_axis_tuser_o    // is_black [0]
);

  `include "rgb_to_cie_xy_chromaticity_assert.svh"

  localparam int unsigned N = rcxy_pkg::NCells;

  logic            chain_valid [N+1];
  logic            chain_ready [N+1];
  rcxy_pkg::cell_t chain_word  [N+1];

  logic        out_valid_q, out_valid_d;
  logic [7:0]  cx_q, cy_q;
  logic        black_q;
  logic [7:0]  cx_d, cy_d;

  rcxy_tristim u_tristim (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .red_i   (s_axis_tdata_i[7:0]),
    .green_i (s_axis_tdata_i[15:8]),
    .blue_i  (s_axis_tdata_i[23:16]),
    .valid_o (chain_valid[0]),
    .ready_i (chain_ready[0]),
    .word_o  (chain_word[0])
  );

  for (genvar i = 0; i < N; i++) begin : g_cell
    rcxy_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_valid[i]),
      .ready_o (chain_ready[i]),
      .word_i  (chain_word[i]),
      .valid_o (chain_valid[i+1]),
      .ready_i (chain_ready[i+1]),
      .word_o  (chain_word[i+1])
    );
  end

  assign chain_ready[N] = !out_valid_q || m_axis_tready_i;

  always_comb begin
    cx_d = (chain_word[N].q_x > rcxy_pkg::QuotW'(rcxy_pkg::ChromaMax)) ?
           rcxy_pkg::ChromaMax : chain_word[N].q_x[7:0];
    cy_d = (chain_word[N].q_y > rcxy_pkg::QuotW'(rcxy_pkg::ChromaMax)) ?
           rcxy_pkg::ChromaMax : chain_word[N].q_y[7:0];
    if (chain_word[N].black) begin
      cx_d = '0;
      cy_d = '0;
    end
  end

  assign out_valid_d = chain_ready[N] ? chain_valid[N] : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (chain_ready[N] && chain_valid[N]) begin
      cx_q    <= cx_d;
      cy_q    <= cy_d;
      black_q <= chain_word[N].black;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {cy_q, cx_q};
  assign m_axis_tuser_o  = black_q;

  `RCXY_ASSERT_IMPL(a_black_zero, out_valid_q && black_q, cx_q == '0 && cy_q == '0)
  `RCXY_ASSERT_IMPL(a_xy_bound, out_valid_q, (9'(cx_q) + 9'(cy_q)) <= 9'd256)
  `RCXY_ASSERT_IMPL(a_stall_src, !s_axis_tready_o, out_valid_q && !m_axis_tready_i)
  `RCXY_ASSERT_NEXT(a_drain, chain_valid[N] && chain_ready[N], out_valid_q)

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;

  localparam int unsigned StallLimit = 4000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned PhaseItems = 150;

  typedef struct packed {
    logic [7:0] x;
    logic [7:0] y;
    logic       black;
  } chroma_t;

  class chroma_board;
    chroma_t     chroma_due[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    // Tristimulus sums in thousandths, truncated, then x and y scaled by 256.
    function chroma_t predict_chroma(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int unsigned tx, ty, tz, s, qx, qy;
      chroma_t c;
      tx = (607 * r + 174 * g + 200 * b) / 1000;
      ty = (299 * r + 587 * g + 114 * b) / 1000;
      tz = (66 * g + 1111 * b) / 1000;
      s = tx + ty + tz;
      if (s == 0) begin
        c.x = 8'd0;
        c.y = 8'd0;
        c.black = 1'b1;
      end else begin
        qx = (256 * tx) / s;
        qy = (256 * ty) / s;
        c.x = (qx > 255) ? 8'd255 : qx[7:0];
        c.y = (qy > 255) ? 8'd255 : qy[7:0];
        c.black = 1'b0;
      end
      return c;
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
    endtask

    function void note_pixel(logic [23:0] word);
      chroma_due.push_back(predict_chroma(word[7:0], word[15:8], word[23:16]));
    endfunction

    task check_chroma(logic [15:0] word, logic user);
      chroma_t want;
      if (chroma_due.size() == 0) begin
        report($sformatf("unexpected word x=%0d y=%0d black=%0d",
                         word[7:0], word[15:8], user));
      end else begin
        want = chroma_due.pop_front();
        if (word[7:0] !== want.x)
          report($sformatf("chroma_x got %0d want %0d", word[7:0], want.x));
        if (word[15:8] !== want.y)
          report($sformatf("chroma_y got %0d want %0d", word[15:8], want.y));
        if (user !== want.black)
          report($sformatf("is_black got %0d want %0d", user, want.black));
      end
    endtask

    function int unsigned pending();
      return chroma_due.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = 24'd0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tuser;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles = 0;

  chroma_board board = new();

  rgb_to_cie_xy_chromaticity dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_tvalid && s_tready) board.note_pixel(s_tdata);
    if (rst_ni && m_tvalid && m_tready) board.check_chroma(m_tdata, m_tuser);
  end

  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("timeout: no word moved in %0d cycles", StallLimit);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {b, g, r};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
  endtask

  // hold the input until every expected word has come back
  task drain_outputs();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  task send_random_pixel();
    if ($urandom_range(3) == 0)
      send_pixel(8'($urandom_range(7)), 8'($urandom_range(7)), 8'($urandom_range(7)));
    else
      send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                 8'($urandom_range(255)));
  endtask

  initial begin
    int unsigned idle_pcts [4];
    int unsigned stall_pcts [4];
    idle_pcts = '{0, 77, 0, 12};
    stall_pcts = '{0, 0, 77, 12};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // black, white, pure primaries and mixes
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    // inputs that truncate to black, two of them nonzero
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd1, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd0);
    // x alone or y alone nonzero: quotient of 256 saturates
    send_pixel(8'd3, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd2, 8'd0);
    send_pixel(8'd1, 8'd1, 8'd1);
    send_pixel(8'd128, 8'd64, 8'd32);
    send_pixel(8'd170, 8'd85, 8'd170);
    send_pixel(8'd85, 8'd170, 8'd85);
    send_pixel(8'd1, 8'd255, 8'd1);
    send_pixel(8'd255, 8'd1, 8'd1);
    send_pixel(8'd1, 8'd1, 8'd255);
    drain_outputs();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_pcts[p];
      recv_stall_pct = stall_pcts[p];
      for (int i = 0; i < PhaseItems; i++) send_random_pixel();
      drain_outputs();
    end

    recv_stall_pct = 0;
    repeat (DrainCycles) @(posedge clk_i);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
